// File: rtl/srec_pkg.sv
`timescale 1ns / 1ps

package srec_pkg;

    localparam logic [7:0]  CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0]  CHAR_NINE     = 8'h39;
    localparam logic [7:0]  CHAR_UPPER_A  = 8'h41;
    // Count field includes two address bytes and one checksum byte
    localparam logic [8:0]  COUNT_BIAS    = 9'd3;
    localparam logic [15:0] ADDR_LOW_INIT = 16'hFFFF;
    localparam logic [2:0]  COUNT_DIGITS  = 3'd2;
    localparam logic [2:0]  ADDR_DIGITS   = 3'd4;
    localparam logic [2:0]  BYTE_DIGITS   = 3'd2;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        stopped;
        logic [15:0] lowest_addr;
        logic [16:0] highest_end;
    } t_result;

    // Letters from 'A' up map to 10 and beyond, anything else counts from '0';
    // keep only the low four bits, nothing is rejected
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= CHAR_UPPER_A) begin
                v = c - 8'h37;
            end else begin
                v = c - 8'h30;
            end
            nibble_of = v[3:0];
        end
    endfunction

endpackage

// File: rtl/srec_core.sv
`timescale 1ns / 1ps

module srec_core import srec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_REST
    } t_phase;

    t_phase             r_phase,       n_phase;
    logic [2:0]         r_digit_count, n_digit_count;
    logic [15:0]        r_hex_accum,   n_hex_accum;
    logic signed [8:0]  r_data_length, n_data_length;
    logic [15:0]        r_record_addr, n_record_addr;
    logic [7:0]         r_byte_index,  n_byte_index;
    logic [15:0]        r_min_start,   n_min_start;
    logic [16:0]        r_max_end,     n_max_end;
    logic               r_halted,      n_halted;
    t_result            r_result,      n_result;

    logic [3:0]         w_nib;
    logic [2:0]         w_digit_inc;
    logic [15:0]        w_shift;
    logic [7:0]         w_byte_shift;
    logic signed [8:0]  w_length;
    logic signed [17:0] w_end;
    logic [7:0]         w_index_inc;
    logic               w_last_byte;

    assign w_nib        = nibble_of(i_char);
    assign w_digit_inc  = r_digit_count + 3'd1;
    assign w_shift      = {r_hex_accum[11:0], w_nib};
    assign w_byte_shift = {r_hex_accum[3:0], w_nib};
    assign w_length     = $signed({1'b0, w_shift[7:0]} - COUNT_BIAS);
    assign w_end        = $signed({2'b00, w_shift}) + 18'(r_data_length) - 18'sd1;
    assign w_index_inc  = r_byte_index + 8'd1;
    assign w_last_byte  = $signed({2'b00, w_index_inc}) >= 10'(r_data_length);

    always_comb begin
        n_phase       = r_phase;
        n_digit_count = r_digit_count;
        n_hex_accum   = r_hex_accum;
        n_data_length = r_data_length;
        n_record_addr = r_record_addr;
        n_byte_index  = r_byte_index;
        n_min_start   = r_min_start;
        n_max_end     = r_max_end;
        n_halted      = r_halted;
        n_result      = '0;

        if (!r_halted) begin
            if (i_char == CHAR_NEWLINE) begin
                n_phase       = PH_SKIP;
                n_digit_count = '0;
                n_hex_accum   = '0;
            end else begin
                unique case (r_phase)
                    PH_SKIP: begin
                        n_phase = PH_TYPE;
                    end
                    PH_TYPE: begin
                        if (i_char == CHAR_NINE) begin
                            n_halted = 1'b1;
                        end else begin
                            n_phase       = PH_COUNT;
                            n_digit_count = '0;
                            n_hex_accum   = '0;
                        end
                    end
                    PH_COUNT: begin
                        n_hex_accum   = w_shift;
                        n_digit_count = w_digit_inc;
                        if (w_digit_inc >= COUNT_DIGITS) begin
                            n_data_length = w_length;
                            n_phase       = PH_ADDR;
                            n_digit_count = '0;
                            n_hex_accum   = '0;
                        end
                    end
                    PH_ADDR: begin
                        n_hex_accum   = w_shift;
                        n_digit_count = w_digit_inc;
                        if (w_digit_inc >= ADDR_DIGITS) begin
                            n_record_addr = w_shift;
                            n_byte_index  = '0;
                            if (w_shift < r_min_start) begin
                                n_min_start = w_shift;
                            end
                            // signed compare: a negative end never wins
                            if (w_end > $signed({1'b0, r_max_end})) begin
                                n_max_end = w_end[16:0];
                            end
                            n_phase       = (r_data_length > 9'sd0) ? PH_DATA : PH_REST;
                            n_digit_count = '0;
                            n_hex_accum   = '0;
                        end
                    end
                    PH_DATA: begin
                        n_hex_accum   = {8'h00, w_byte_shift};
                        n_digit_count = w_digit_inc;
                        if (w_digit_inc >= BYTE_DIGITS) begin
                            n_result.write_valid = 1'b1;
                            n_result.write_addr  = r_record_addr + 16'(r_byte_index);
                            n_result.write_data  = w_byte_shift;
                            n_byte_index         = w_index_inc;
                            n_digit_count        = '0;
                            n_hex_accum          = '0;
                            if (w_last_byte) begin
                                n_phase = PH_REST;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_REST;
                    end
                endcase
            end
        end

        n_result.stopped     = n_halted;
        n_result.lowest_addr = n_min_start;
        n_result.highest_end = n_max_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SKIP;
            r_digit_count <= '0;
            r_hex_accum   <= '0;
            r_data_length <= '0;
            r_record_addr <= '0;
            r_byte_index  <= '0;
            r_min_start   <= ADDR_LOW_INIT;
            r_max_end     <= '0;
            r_halted      <= 1'b0;
            r_result      <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_hex_accum   <= n_hex_accum;
            r_data_length <= n_data_length;
            r_record_addr <= n_record_addr;
            r_byte_index  <= n_byte_index;
            r_min_start   <= n_min_start;
            r_max_end     <= n_max_end;
            r_halted      <= n_halted;
            r_result      <= n_result;
        end
    end

    assign o_result = r_result;

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped");

    a_halt_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_halted) |=> (!o_result.write_valid && o_result.stopped))
        else $error("write issued after halt");

    a_skip_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_SKIP) |=> !o_result.write_valid)
        else $error("write issued on first character of a line");

    a_hold_on_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_step && !$past(!i_rst_n)) |=> $stable(o_result))
        else $error("result changed without a step");

endmodule

// File: rtl/srec_record_decoder_unit.sv
`timescale 1ns / 1ps

// S-record text decoder.
// Feed S-record text one character per transaction on the s_axis channel
// (tdata = the character, 0x0A ends a line). Every accepted character yields
// exactly one result transaction on m_axis: tuser flags a decoded data byte,
// tdata carries its address and value along with the running status
// (halt flag after a type 9 record, lowest record start, highest record end).
// Throughput: one character per clock while m_axis accepts results; the only
// loop is the per-character parser state update.
// Path: an accepted character goes into the input register and is then parsed
// into the parser's result register, from which its result transaction is
// offered on m_axis.
// Receiver stall: the result register holds; one more character may wait in
// the input register, after which s_axis_tready drops until m_axis moves.
// Reset (synchronous, active low): parser returns to the start of a line,
// lowest start = 0xFFFF, highest end = 0, halt cleared, both stages empty.
module srec_record_decoder_unit import srec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] write_addr, [23:16] write_data,
                                        // [24] stopped, [40:25] lowest_addr,
                                        // [57:41] highest_end, [63:58] zero
    output logic [0:0]  m_axis_tuser    // [0] write_valid
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    logic       w_advance;
    t_result    w_result;

    // Move the held character into the parser when the result slot is free
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        // Capture payload on every accepted transaction
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
        end
    end

    srec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_char   (r_in_char),
        .o_result (w_result)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = w_result.write_valid;
    assign m_axis_tdata    = {6'b000000,
                              w_result.highest_end,
                              w_result.lowest_addr,
                              w_result.stopped,
                              w_result.write_data,
                              w_result.write_addr};

endmodule
